@@ rtl/core/atbm_pkg.sv @@
// ----------------------------------------------------------------------------
// atbm_pkg: shared types and constants
// Types and constants used by the triangle catalog match search unit.
// ----------------------------------------------------------------------------
package atbm_pkg;

   localparam logic [0:0] ACT_WRITE = 1'b0;
   localparam logic [0:0] ACT_QUERY = 1'b1;

   localparam int TOL_WIDTH   = 16;
   localparam int COUNT_WIDTH = 11;
   localparam int DEV_WIDTH   = 34;

   localparam logic [0:0] CSR_TOLERANCE = 1'b0;
   localparam logic [0:0] CSR_ENTRIES   = 1'b1;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd655;

   // Status handed from the sum stage to the best-match cell.
   typedef struct packed {
      logic                 valid;
      logic                 in_window;
      logic [DEV_WIDTH-1:0] dev;
   } cell_stat_type;

endpackage

@@ rtl/core/angle_triple_best_match_search_unit.sv @@
// ----------------------------------------------------------------------------
// angle_triple_best_match_search_unit: triangle catalog best-match search
// Stores catalog entries and finds the entry nearest a key angle triple within the tolerance window.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | content
// req     | in  | tvalid/tready      | write entry or search query
// rsp     | out | tvalid/tready      | best match of one query
// csr     | in  | wr_en              | tolerance (0), entries_in_use (1)
//
// A query with N = entries_in_use (capped at TABLE_DEPTH) keeps the unit busy
// while it scans N table entries, one entry per cycle from the single memory
// read port, drains the pipeline, then fetches and sends the result. An empty
// search (N = 0) reads no entries and goes on to result fetch and send.
// Reset clears control and sets the CSRs to defaults; table contents are undefined until written.
// A finished response waits in the output register and blocks new requests
// until rsp_tready takes it.
// ----------------------------------------------------------------------------
module angle_triple_best_match_search_unit #(
   parameter int TABLE_DEPTH     = 1024,
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int ID_WIDTH        = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // action, entry_index[10], star_id_a/b/c, angle_first/second/between, zero fill
   input  logic [((1+10+3*ID_WIDTH+3*(ANGLE_FRAC_BITS+2))+7)/8*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // found, match_id_a/b/c, match_angle_first/second/between, deviation_sq, zero fill
   output logic [((1+3*ID_WIDTH+3*(ANGLE_FRAC_BITS+2)+34)+7)/8*8-1:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int AW        = ANGLE_FRAC_BITS + 2;
   localparam int IW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW        = $clog2(TABLE_DEPTH + 1);
   localparam int DW        = atbm_pkg::DEV_WIDTH;
   localparam int RSP_BITS  = 1 + 3*ID_WIDTH + 3*AW + DW;
   localparam int RSP_W     = (RSP_BITS + 7) / 8 * 8;
   localparam int PIPE      = 4;   // read, diff, square, sum

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FETCH = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   // request unpack
   logic                  r_action;
   logic [9:0]            r_index;
   logic [3*ID_WIDTH-1:0] r_ids;
   logic [3*AW-1:0]       r_angles;
   assign r_action = req_tdata[0];
   assign r_index  = req_tdata[10:1];
   assign r_ids    = req_tdata[11 +: 3*ID_WIDTH];
   assign r_angles = req_tdata[11+3*ID_WIDTH +: 3*AW];

   // configuration
   logic [atbm_pkg::TOL_WIDTH-1:0]   tol_ff;
   logic [atbm_pkg::COUNT_WIDTH-1:0] count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= atbm_pkg::TOL_RESET;
         count_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            atbm_pkg::CSR_TOLERANCE: tol_ff   <= csr_wdata;
            atbm_pkg::CSR_ENTRIES:   count_ff <= csr_wdata[atbm_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // control
   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in, limit;
   logic [PIPE-1:0]  vpipe_ff;
   logic [3*AW-1:0]  key_ff;
   logic             rsp_valid_ff;
   logic             start;
   logic             accept;

   assign limit = (int'(count_ff) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_ff);
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (r_action == atbm_pkg::ACT_QUERY);

   logic issue;
   assign issue = (state_ff == ST_SCAN) && (cnt_ff < limit);

   logic found_w;
   logic [IW-1:0] best_idx_w;
   logic [DW-1:0] best_dev_w;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_SCAN;
            cnt_in   = '0;
         end
         ST_SCAN: begin
            if (issue) cnt_in = cnt_ff + 1'b1;
            if (!issue && vpipe_ff == '0) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_SEND;
         ST_SEND:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         vpipe_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vpipe_ff <= {vpipe_ff[PIPE-2:0], issue};
      end
      if (start) key_ff <= r_angles;
   end

   // catalog memory, one write port, one read port used for scan read and result fetch
   logic [3*ID_WIDTH-1:0] id_mem [TABLE_DEPTH];
   logic [3*AW-1:0]       ang_mem [TABLE_DEPTH];
   logic [3*ID_WIDTH-1:0] id_rd_ff;
   logic [3*AW-1:0]       ang_rd_ff;
   logic [IW-1:0]         rd_addr;
   logic                  wr_ok;

   assign wr_ok   = accept && (r_action == atbm_pkg::ACT_WRITE) &&
                    (int'(r_index) < TABLE_DEPTH);
   assign rd_addr = (state_ff == ST_FETCH) ? best_idx_w : cnt_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         id_mem[IW'(r_index)]  <= r_ids;
         ang_mem[IW'(r_index)] <= r_angles;
      end
      id_rd_ff  <= id_mem[rd_addr];
      ang_rd_ff <= ang_mem[rd_addr];
   end

   // index tracking alongside the pipe
   logic [IW-1:0] idx_pipe_ff [PIPE];
   always_ff @(posedge clock) begin
      idx_pipe_ff[0] <= cnt_ff[IW-1:0];
      for (int i = 1; i < PIPE; i++) idx_pipe_ff[i] <= idx_pipe_ff[i-1];
   end

   // row of difference cells, one per angle
   logic [2:0]        inside_w;
   logic [2*AW-1:0]   sq_w [3];
   for (genvar g = 0; g < 3; g++) begin : g_cell
      atbm_diff_cell #(.ANGLE_WIDTH(AW)) u_cell (
         .clock     (clock),
         .stored    (ang_rd_ff[g*AW +: AW]),
         .key       (key_ff[g*AW +: AW]),
         .tolerance (tol_ff),
         .in_window (inside_w[g]),
         .square    (sq_w[g])
      );
   end

   // sum stage
   atbm_pkg::cell_stat_type stat_ff;
   always_ff @(posedge clock) begin
      stat_ff.valid     <= vpipe_ff[2];
      stat_ff.in_window <= &inside_w;
      stat_ff.dev       <= DW'(sq_w[0]) + DW'(sq_w[1]) + DW'(sq_w[2]);
   end

   atbm_best_cell #(.IDX_WIDTH(IW)) u_best (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .stat     (stat_ff),
      .idx      (idx_pipe_ff[PIPE-1]),
      .found    (found_w),
      .best_idx (best_idx_w),
      .best_dev (best_dev_w)
   );

   // response register
   logic [RSP_W-1:0] rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_SEND) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_SEND) begin
         rsp_ff <= found_w ?
            RSP_W'({best_dev_w, ang_rd_ff, id_rd_ff, 1'b1}) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= limit)) else $error("scan overrun");
   a_send_then_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |=> rsp_valid_ff) else $error("response lost");
   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |=> !vpipe_ff[0]) else $error("stray issue");
`endif
endmodule

@@ rtl/core/atbm_diff_cell.sv @@
// ----------------------------------------------------------------------------
// atbm_diff_cell: one angle difference cell
// Registers |stored - key| for one angle, its window test and its square.
// ----------------------------------------------------------------------------
module atbm_diff_cell #(
   parameter int ANGLE_WIDTH = 18
) (
   input  logic                                  clock,
   input  logic [ANGLE_WIDTH-1:0]                stored,
   input  logic [ANGLE_WIDTH-1:0]                key,
   input  logic [atbm_pkg::TOL_WIDTH-1:0]        tolerance,
   output logic                                  in_window,
   output logic [2*ANGLE_WIDTH-1:0]              square
);
   localparam int CMP_W = (ANGLE_WIDTH > atbm_pkg::TOL_WIDTH) ?
                          ANGLE_WIDTH : atbm_pkg::TOL_WIDTH;

   logic [ANGLE_WIDTH-1:0]   dist_in, dist_ff;
   logic                     inside_in, inside_ff;
   logic [2*ANGLE_WIDTH-1:0] square_ff;

   assign dist_in   = (stored > key) ? stored - key : key - stored;
   assign inside_in = (CMP_W'(dist_in) < CMP_W'(tolerance));

   // stage 1: difference, stage 2: square
   always_ff @(posedge clock) begin
      dist_ff   <= dist_in;
      inside_ff <= inside_in;
      square_ff <= dist_ff * dist_ff;
   end

   logic inside_d_ff;
   always_ff @(posedge clock) begin
      inside_d_ff <= inside_ff;
   end

   assign in_window = inside_d_ff;
   assign square    = square_ff;
endmodule

@@ rtl/core/atbm_best_cell.sv @@
// ----------------------------------------------------------------------------
// atbm_best_cell: running best-match cell
// Keeps the lowest in-window deviation seen over one scan, earliest wins on a tie.
// ----------------------------------------------------------------------------
module atbm_best_cell #(
   parameter int IDX_WIDTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  atbm_pkg::cell_stat_type             stat,
   input  logic [IDX_WIDTH-1:0]                idx,
   output logic                                found,
   output logic [IDX_WIDTH-1:0]                best_idx,
   output logic [atbm_pkg::DEV_WIDTH-1:0]      best_dev
);
   logic                               found_ff, found_in;
   logic [IDX_WIDTH-1:0]               idx_ff, idx_in;
   logic [atbm_pkg::DEV_WIDTH-1:0]     dev_ff, dev_in;

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      dev_in   = dev_ff;
      if (start) begin
         found_in = 1'b0;
      end else if (stat.valid && stat.in_window && (!found_ff || stat.dev < dev_ff)) begin
         found_in = 1'b1;
         idx_in   = idx;
         dev_in   = stat.dev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff <= idx_in;
      dev_ff <= dev_in;
   end

   assign found    = found_ff;
   assign best_idx = idx_ff;
   assign best_dev = dev_ff;
endmodule
